@@ sv/ber_value_stream_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// ber value stream decoder assertion macros
// shared property forms for the decoder's concurrent checks
// ----------------------------------------------------------------------------
`ifndef BER_VALUE_STREAM_DECODER_ASSERT_SVH
`define BER_VALUE_STREAM_DECODER_ASSERT_SVH

// condition in a cycle implies a consequence in the same cycle
`define BVSD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ber decoder check failed");

// condition in a cycle implies a consequence in the next cycle
`define BVSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ber decoder check failed");

`endif

@@ sv/ber_vsd_pkg.sv @@
// ----------------------------------------------------------------------------
// ber value stream decoder package
// tag codes, result kinds, error codes, decode phases and the result word type
// ----------------------------------------------------------------------------
package ber_vsd_pkg;

    localparam logic [7:0] TAG_INTEGER = 8'h02;
    localparam logic [7:0] TAG_OCTETS  = 8'h04;
    localparam logic [7:0] TAG_NULL    = 8'h05;
    localparam logic [7:0] TAG_OID     = 8'h06;
    localparam logic [7:0] TAG_IPADDR  = 8'h40;
    localparam logic [7:0] TAG_COUNTER = 8'h41;
    localparam logic [7:0] TAG_GAUGE   = 8'h42;
    localparam logic [7:0] TAG_TICKS   = 8'h43;
    localparam logic [7:0] TAG_OPAQUE  = 8'h44;

    localparam logic [2:0] KIND_SINT    = 3'd0;
    localparam logic [2:0] KIND_UINT    = 3'd1;
    localparam logic [2:0] KIND_NULL    = 3'd2;
    localparam logic [2:0] KIND_STRHDR  = 3'd3;
    localparam logic [2:0] KIND_CONTENT = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_TAG     = 3'd1;
    localparam logic [2:0] ERR_LONGLEN = 3'd2;
    localparam logic [2:0] ERR_BADLEN  = 3'd3;
    localparam logic [2:0] ERR_TRUNC   = 3'd4;

    localparam int unsigned MAX_LEN_OCTETS = 2;

    typedef enum logic [2:0] {
        PH_TAG       = 3'd0,
        PH_LEN_FIRST = 3'd1,
        PH_LEN_EXT   = 3'd2,
        PH_CONTENT   = 3'd3,
        PH_DISCARD   = 3'd4
    } phase_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [7:0]  tag;
        logic [31:0] value_bits;
        logic [15:0] length_out;
        logic [7:0]  content_byte;
        logic        last_of_value;
        logic [2:0]  error_code;
    } result_t;

    function automatic logic is_uint_tag(input logic [7:0] t);
        return (t == TAG_COUNTER) || (t == TAG_GAUGE) || (t == TAG_TICKS);
    endfunction

    function automatic logic is_string_tag(input logic [7:0] t);
        return (t == TAG_OCTETS) || (t == TAG_IPADDR) || (t == TAG_OID)
            || (t == TAG_OPAQUE);
    endfunction

    function automatic logic is_num_tag(input logic [7:0] t);
        return (t == TAG_INTEGER) || is_uint_tag(t);
    endfunction

endpackage

@@ sv/ber_vsd_in_stage.sv @@
// ----------------------------------------------------------------------------
// ber vsd input stage
// holds one incoming byte word until the decode step consumes it
// ----------------------------------------------------------------------------
module ber_vsd_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_in,
    input  logic       end_of_buffer,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte,
    output logic       held_eob
);
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       eob_reg;

    // slot frees up in the same cycle the decoder takes the held word
    assign in_ready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= byte_in;
            eob_reg  <= end_of_buffer;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_eob   = eob_reg;
endmodule

@@ sv/ber_vsd_core.sv @@
// ----------------------------------------------------------------------------
// ber vsd core
// tlv parse state and the single-pass decode of one byte into a result word
// ----------------------------------------------------------------------------
`include "ber_value_stream_decoder_assert.svh"

module ber_vsd_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          b,
    input  logic                eob,
    output ber_vsd_pkg::result_t res
);
    import ber_vsd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  tag_reg, tag_next;
    logic [1:0]  octs_reg, octs_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] left_reg, left_next;
    logic [31:0] acc_reg, acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG;
            tag_reg   <= 8'h00;
            octs_reg  <= 2'd0;
            len_reg   <= 16'd0;
            left_reg  <= 16'd0;
            acc_reg   <= 32'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            tag_reg   <= tag_next;
            octs_reg  <= octs_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            acc_reg   <= acc_next;
        end
    end

    always_comb
    begin
        logic        ld;
        logic        fail;
        logic [2:0]  fail_code;
        logic [6:0]  n;
        logic [15:0] left_dec;
        logic [31:0] base;

        phase_next = phase_reg;
        tag_next   = tag_reg;
        octs_next  = octs_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        acc_next   = acc_reg;
        res        = '0;
        ld         = 1'b0;
        fail       = 1'b0;
        fail_code  = ERR_NONE;
        n          = b[6:0];
        left_dec   = left_reg - 16'd1;
        base       = acc_reg;

        if (step)
        begin
            case (phase_reg)
                PH_TAG:
                begin
                    tag_next = b;
                    if (!(b == TAG_NULL || is_num_tag(b) || is_string_tag(b)))
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_TAG;
                    end
                    else if (eob)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_TRUNC;
                    end
                    else
                    begin
                        phase_next = PH_LEN_FIRST;
                    end
                end
                PH_LEN_FIRST:
                begin
                    if (!b[7])
                    begin
                        len_next = {8'h00, b};
                        ld       = 1'b1;
                    end
                    else if (n == 7'd0 || n > 7'(MAX_LEN_OCTETS))
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_LONGLEN;
                    end
                    else
                    begin
                        octs_next = n[1:0];
                        len_next  = 16'd0;
                        if (eob)
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_TRUNC;
                        end
                        else
                        begin
                            phase_next = PH_LEN_EXT;
                        end
                    end
                end
                PH_LEN_EXT:
                begin
                    len_next  = {len_reg[7:0], b};
                    octs_next = octs_reg - 2'd1;
                    if (octs_next == 2'd0)
                    begin
                        ld = 1'b1;
                    end
                    else if (eob)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_TRUNC;
                    end
                end
                PH_CONTENT:
                begin
                    left_next = left_dec;
                    if (is_num_tag(tag_reg))
                    begin
                        // first content octet seeds the sign extension
                        if (left_reg == len_reg)
                        begin
                            base = (tag_reg == TAG_INTEGER && b[7]) ? 32'hFFFF_FFFF
                                                                     : 32'd0;
                        end
                        acc_next = {base[23:0], b};
                        if (left_dec == 16'd0)
                        begin
                            res.valid         = 1'b1;
                            res.kind          = (tag_reg == TAG_INTEGER) ? KIND_SINT
                                                                         : KIND_UINT;
                            res.value_bits    = acc_next;
                            res.length_out    = len_reg;
                            res.last_of_value = 1'b1;
                            phase_next        = PH_TAG;
                        end
                        else if (eob)
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_TRUNC;
                        end
                    end
                    else
                    begin
                        if (left_dec == 16'd0)
                        begin
                            res.valid         = 1'b1;
                            res.kind          = KIND_CONTENT;
                            res.length_out    = len_reg;
                            res.content_byte  = b;
                            res.last_of_value = 1'b1;
                            phase_next        = PH_TAG;
                        end
                        else if (eob)
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_TRUNC;
                        end
                        else
                        begin
                            res.valid        = 1'b1;
                            res.kind         = KIND_CONTENT;
                            res.length_out   = len_reg;
                            res.content_byte = b;
                        end
                    end
                end
                default:
                begin
                    phase_next = eob ? PH_TAG : PH_DISCARD;
                end
            endcase
        end

        // length complete: check it against the tag and start the contents
        if (ld)
        begin
            if (tag_next == TAG_NULL)
            begin
                if (len_next != 16'd0)
                begin
                    fail      = 1'b1;
                    fail_code = ERR_BADLEN;
                end
                else
                begin
                    res.valid         = 1'b1;
                    res.kind          = KIND_NULL;
                    res.last_of_value = 1'b1;
                    phase_next        = PH_TAG;
                end
            end
            else if ((is_num_tag(tag_next) || tag_next == TAG_OID
                      || tag_next == TAG_OPAQUE) && len_next == 16'd0)
            begin
                fail      = 1'b1;
                fail_code = ERR_BADLEN;
            end
            else if (is_num_tag(tag_next))
            begin
                if (eob)
                begin
                    fail      = 1'b1;
                    fail_code = ERR_TRUNC;
                end
                else
                begin
                    left_next  = len_next;
                    acc_next   = 32'd0;
                    phase_next = PH_CONTENT;
                end
            end
            else if (len_next == 16'd0)
            begin
                res.valid         = 1'b1;
                res.kind          = KIND_STRHDR;
                res.last_of_value = 1'b1;
                phase_next        = PH_TAG;
            end
            else if (eob)
            begin
                fail      = 1'b1;
                fail_code = ERR_TRUNC;
            end
            else
            begin
                left_next      = len_next;
                res.valid      = 1'b1;
                res.kind       = KIND_STRHDR;
                res.length_out = len_next;
                phase_next     = PH_CONTENT;
            end
        end

        // error replaces any other result of this byte
        if (fail)
        begin
            res            = '0;
            res.valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.last_of_value = 1'b1;
            res.error_code = fail_code;
            phase_next     = eob ? PH_TAG : PH_DISCARD;
        end

        res.tag = tag_next;
    end

    `BVSD_ASSERT_NEXT(a_discard_ends, step && phase_reg == PH_DISCARD && eob,
                      phase_reg == PH_TAG)
    `BVSD_ASSERT_NEXT(a_last_content, step && phase_reg == PH_CONTENT && left_reg == 16'd1,
                      phase_reg == PH_TAG)
    `BVSD_ASSERT_SAME(a_ext_count, phase_reg == PH_LEN_EXT, octs_reg != 2'd0)
    `BVSD_ASSERT_SAME(a_content_left, phase_reg == PH_CONTENT,
                      left_reg != 16'd0 && left_reg <= len_reg)
endmodule

@@ sv/ber_vsd_out_stage.sv @@
// ----------------------------------------------------------------------------
// ber vsd output stage
// result register that holds a decoded word until the consumer takes it
// ----------------------------------------------------------------------------
module ber_vsd_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  ber_vsd_pkg::result_t res,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          kind,
    output logic [7:0]          tag,
    output logic [31:0]         value_bits,
    output logic [15:0]         length_out,
    output logic [7:0]          content_byte,
    output logic                last_of_value,
    output logic [2:0]          error_code
);
    import ber_vsd_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= res.valid;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            data_reg <= res;
        end
    end

    assign out_valid     = valid_reg;
    assign kind          = data_reg.kind;
    assign tag           = data_reg.tag;
    assign value_bits    = data_reg.value_bits;
    assign length_out    = data_reg.length_out;
    assign content_byte  = data_reg.content_byte;
    assign last_of_value = data_reg.last_of_value;
    assign error_code    = data_reg.error_code;
endmodule

@@ sv/ber_value_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// ber value stream decoder
// decodes a byte stream of snmp ber values into typed result words
// ----------------------------------------------------------------------------
// The decoder takes one byte word per clock while the result register is free
// or draining, and gives at most one result word per byte; a byte goes from the
// input register through a single combinational decode step into the result
// register, and its result word is presented from that register until taken.
// Throughput is one byte per cycle whenever the result register is empty or
// being drained in the same cycle, and is set by that decode step between the
// two registers. After an error, bytes are dropped without results up to and
// including the one marked end_of_buffer.
module ber_value_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    input  logic        end_of_buffer,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  tag,
    output logic [31:0] value_bits,
    output logic [15:0] length_out,
    output logic [7:0]  content_byte,
    output logic        last_of_value,
    output logic [2:0]  error_code
);
    import ber_vsd_pkg::*;

    logic       held_valid;
    logic [7:0] held_byte;
    logic       held_eob;
    logic       advance;
    result_t    res;

    // decode the held word when the result slot is free or draining
    assign advance = held_valid && (!out_valid || out_ready);

    ber_vsd_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .byte_in       (byte_in),
        .end_of_buffer (end_of_buffer),
        .advance       (advance),
        .held_valid    (held_valid),
        .held_byte     (held_byte),
        .held_eob      (held_eob)
    );

    ber_vsd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .b     (held_byte),
        .eob   (held_eob),
        .res   (res)
    );

    ber_vsd_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .res           (res),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .tag           (tag),
        .value_bits    (value_bits),
        .length_out    (length_out),
        .content_byte  (content_byte),
        .last_of_value (last_of_value),
        .error_code    (error_code)
    );
endmodule
